/* rtl/http_request_line_parser_unit_macros.svh */
// ----------------------------------------------------------------------------
// HTTP request line parser assertion macros
// Shorthand for the clocked, reset-qualified checks used by the parser.
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_UNIT_MACROS_SVH

// Same-cycle implication, checked while out of reset.
`define HRLP_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked while out of reset.
`define HRLP_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/hrlp_pkg.sv */
// ----------------------------------------------------------------------------
// HTTP request line parser package
// Shared types, codes and character classes for the parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrlp_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VER_W    = 16;
    localparam int unsigned ROLE_W   = 2;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned POS_W    = 3;
    localparam int unsigned PREFIX_LEN = 5;
    // error_code, major, minor, padded up to whole bytes
    localparam int unsigned RES_BITS = ERR_W + 2 * VER_W;
    localparam int unsigned M_DATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [VER_W-1:0]  VER_MAX  = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_METHOD = 3'd0,
        PH_URI    = 3'd1,
        PH_PREFIX = 3'd2,
        PH_MAJOR  = 3'd3,
        PH_MINOR  = 3'd4,
        PH_ERROR  = 3'd5
    } phase_t;

    typedef enum logic [ROLE_W-1:0] {
        ROLE_METHOD = 2'd0,
        ROLE_URI    = 2'd1,
        ROLE_SEP    = 2'd2,
        ROLE_ERROR  = 2'd3
    } role_t;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE    = 2'd0,
        ERR_METHOD  = 2'd1,
        ERR_URI     = 2'd2,
        ERR_VERSION = 2'd3
    } err_t;

    typedef struct packed {
        phase_t           phase;
        logic [POS_W-1:0] prefix_pos;
        logic             method_seen;
        err_t             error_latch;
        logic [VER_W-1:0] major_acc;
        logic [VER_W-1:0] minor_acc;
    } state_t;

    typedef struct packed {
        role_t            role;
        logic             done;
        err_t             error_code;
        logic [VER_W-1:0] major_version;
        logic [VER_W-1:0] minor_version;
    } result_t;

    localparam state_t STATE_RESET = '{
        phase:       PH_METHOD,
        prefix_pos:  '0,
        method_seen: 1'b0,
        error_latch: ERR_NONE,
        major_acc:   '0,
        minor_acc:   '0
    };

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Token characters: letters, digits and the listed punctuation.
    function automatic logic is_token_char(input logic [BYTE_W-1:0] c);
        logic ok;
        ok = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || is_digit(c);
        case (c)
            8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A, 8'h2B,
            8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: ok = 1'b1;
            default: ;
        endcase
        return ok;
    endfunction

    // Expected byte of the "HTTP/" literal at a given position.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
        logic [BYTE_W-1:0] ch;
        case (pos)
            3'd0:    ch = 8'h48;
            3'd1:    ch = 8'h54;
            3'd2:    ch = 8'h54;
            3'd3:    ch = 8'h50;
            3'd4:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // acc * 10 + digit, saturating; times ten is two shifts and an add.
    function automatic logic [VER_W-1:0] add_digit(input logic [VER_W-1:0] acc,
                                                   input logic [BYTE_W-1:0] c);
        logic [VER_W+3:0] v;
        v = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {{VER_W{1'b0}}, c[3:0]};
        return (v > {4'd0, VER_MAX}) ? VER_MAX : v[VER_W-1:0];
    endfunction

endpackage

`default_nettype wire

/* rtl/hrlp_in_stage.sv */
// ----------------------------------------------------------------------------
// HTTP request line parser input stage
// Registers one incoming byte and its end-of-line flag.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_in_stage
    import hrlp_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              in_valid,
    input  wire logic [BYTE_W-1:0] in_byte,
    input  wire logic              in_last,
    output logic                   in_ready,
    input  wire logic              take,
    output logic                   held_valid,
    output logic [BYTE_W-1:0]      held_byte,
    output logic                   held_last
);

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    // The slot refills in the same cycle it drains.
    assign in_ready = !valid_reg || take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            byte_reg <= in_byte;
            last_reg <= in_last;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_last  = last_reg;

endmodule

`default_nettype wire

/* rtl/hrlp_step.sv */
// ----------------------------------------------------------------------------
// HTTP request line parser step logic
// Next parser state and the result for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module hrlp_step
    import hrlp_pkg::*;
(
    input  wire state_t            st,
    input  wire logic [BYTE_W-1:0] c,
    input  wire logic              fin,
    output state_t                 st_next,
    output result_t                res
);

    always_comb begin
        state_t nx;
        err_t   err;
        role_t  role;

        nx   = st;
        role = ROLE_ERROR;
        err  = ERR_NONE;

        case (st.phase)
            PH_METHOD: begin
                if (c == CH_SPACE) begin
                    if (st.method_seen) begin
                        nx.phase = PH_URI;
                        role     = ROLE_SEP;
                    end else begin
                        nx.phase       = PH_ERROR;
                        nx.error_latch = ERR_METHOD;
                    end
                end else if (is_token_char(c)) begin
                    nx.method_seen = 1'b1;
                    role           = ROLE_METHOD;
                end else begin
                    nx.phase       = PH_ERROR;
                    nx.error_latch = ERR_METHOD;
                end
            end
            PH_URI: begin
                if (c == CH_SPACE) begin
                    nx.phase      = PH_PREFIX;
                    nx.prefix_pos = '0;
                    role          = ROLE_SEP;
                end else begin
                    role = ROLE_URI;
                end
            end
            PH_PREFIX: begin
                if ((st.prefix_pos < POS_W'(PREFIX_LEN)) && (c == prefix_char(st.prefix_pos)))
                begin
                    role          = ROLE_SEP;
                    nx.prefix_pos = st.prefix_pos + 1'b1;
                    if (st.prefix_pos == POS_W'(PREFIX_LEN - 1)) begin
                        nx.phase = PH_MAJOR;
                    end
                end else begin
                    nx.phase       = PH_ERROR;
                    nx.error_latch = ERR_VERSION;
                end
            end
            PH_MAJOR: begin
                if (is_digit(c)) begin
                    nx.major_acc = add_digit(st.major_acc, c);
                    role         = ROLE_SEP;
                end else if (c == CH_DOT) begin
                    nx.phase = PH_MINOR;
                    role     = ROLE_SEP;
                end else begin
                    nx.phase       = PH_ERROR;
                    nx.error_latch = ERR_VERSION;
                end
            end
            PH_MINOR: begin
                if (is_digit(c)) begin
                    nx.minor_acc = add_digit(st.minor_acc, c);
                    role         = ROLE_SEP;
                end else begin
                    nx.phase       = PH_ERROR;
                    nx.error_latch = ERR_VERSION;
                end
            end
            default: begin
                nx.phase = PH_ERROR;
            end
        endcase

        res.role          = role;
        res.done          = fin;
        res.major_version = '0;
        res.minor_version = '0;

        if (fin) begin
            case (nx.phase)
                PH_METHOD: err = ERR_METHOD;
                PH_URI:    err = ERR_URI;
                PH_PREFIX: err = ERR_VERSION;
                PH_MAJOR:  err = ERR_VERSION;
                PH_MINOR:  err = ERR_NONE;
                default:   err = nx.error_latch;
            endcase
            if (err == ERR_NONE) begin
                res.major_version = nx.major_acc;
                res.minor_version = nx.minor_acc;
            end
            // The next line starts from a clean parser.
            nx = STATE_RESET;
        end

        res.error_code = err;
        st_next        = nx;
    end

endmodule

`default_nettype wire

/* rtl/http_request_line_parser_unit.sv */
// ----------------------------------------------------------------------------
// HTTP request line parser
// Checks a request line byte by byte and tags the role of every byte.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one byte of a request line per request in
//   s_tdata, with s_tlast high on the final byte (line terminator stripped).
//   The master stream returns one result per byte: m_tuser is the byte role,
//   m_tlast marks the result of the final byte, and m_tdata holds the error
//   code and the major and minor version numbers, which are zero except on
//   the final byte of a line.
//   An accepted byte waits in the input register, and the parse step writes
//   the result register when it advances. Throughput is one byte per cycle
//   while m_tready stays high, set by the single state update per byte.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the start of a line. The parser also restarts on its own after
//   each final byte.
//   When m_tready stalls a valid result, that register holds; an empty input
//   register takes one more byte, after which s_tready drops until drained.
// ----------------------------------------------------------------------------
`default_nettype none

`include "http_request_line_parser_unit_macros.svh"

module http_request_line_parser_unit
    import hrlp_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,  // [7:0] byte_in
    input  wire logic                s_tlast,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,  // [1:0] error_code, [17:2] major_version,
                                               // [33:18] minor_version, rest zero
    output logic [ROLE_W-1:0]        m_tuser,  // [1:0] role
    output logic                     m_tlast   // done_res
);

    logic              held_valid;
    logic [BYTE_W-1:0] held_byte;
    logic              held_last;
    logic              out_free;
    logic              advance;

    state_t  state_reg;
    state_t  state_next;
    result_t step_res;
    result_t res_reg;
    logic    out_valid_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = held_valid && out_free;

    hrlp_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_byte    (s_tdata),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .take       (advance),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_last  (held_last)
    );

    hrlp_step u_step (
        .st      (state_reg),
        .c       (held_byte),
        .fin     (held_last),
        .st_next (state_next),
        .res     (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= STATE_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (out_free) begin
                out_valid_reg <= held_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = res_reg.role;
    assign m_tlast  = res_reg.done;
    assign m_tdata  = {{(M_DATA_W - RES_BITS){1'b0}}, res_reg.minor_version,
                       res_reg.major_version, res_reg.error_code};

    `HRLP_ASSERT_NOW(a_mid_line_clean, aclk, aresetn, m_tvalid && !m_tlast, res_reg.error_code == ERR_NONE && res_reg.major_version == '0 && res_reg.minor_version == '0, "hrlp: status fields set before the final byte")
    `HRLP_ASSERT_NOW(a_error_no_version, aclk, aresetn, m_tvalid && res_reg.error_code != ERR_NONE, res_reg.major_version == '0 && res_reg.minor_version == '0, "hrlp: version reported with an error")
    `HRLP_ASSERT_NEXT(a_restart_after_line, aclk, aresetn, advance && held_last, state_reg.phase == PH_METHOD && !state_reg.method_seen, "hrlp: parser did not restart after the final byte")
    `HRLP_ASSERT_NOW(a_error_latched, aclk, aresetn, state_reg.phase == PH_ERROR, state_reg.error_latch != ERR_NONE, "hrlp: error phase without an error code")

endmodule

`default_nettype wire
